// ===== rtl/dtsg_pkg.sv =====
// Package: shared types, constants and oscillator arithmetic of the DTMF tone sequence generator.
`timescale 1ns / 1ps
package dtsg_pkg;

  localparam int MAX_KEYS = 32;
  localparam int KEY_IDX_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int KEY_CNT_W = $clog2(MAX_KEYS + 1);

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TONE_FRAMES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_FRAMES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH = 2'd2;

  localparam logic [15:0] TONE_FRAMES_RST  = 16'd1;
  localparam logic [15:0] PAUSE_FRAMES_RST = 16'd1;
  localparam logic [15:0] FRAME_LENGTH_RST = 16'd160;

  localparam logic [31:0] S2_INIT = 32'd31000;
  localparam logic signed [33:0] MUL_RND = 34'sd16384;

  localparam logic [15:0] ROW_COEF [4] = '{16'd27980, 16'd26956, 16'd25701, 16'd24218};
  localparam logic [15:0] COL_COEF [4] = '{16'd19073, 16'd16325, 16'd13085, 16'd9315};

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_CLEAR = 2'd2
  } dtsg_action_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] key_code;
    logic       last_key;
  } dtsg_in_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               active;
    logic               in_tone;
    logic               accepted;
  } dtsg_out_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] row;
    logic [15:0] col;
  } dtsg_coef_t;

  function automatic dtsg_coef_t key_coef(input logic [7:0] key);
    logic       v;
    logic [1:0] r;
    logic [1:0] c;
    dtsg_coef_t res;
    v = 1'b1;
    r = 2'd0;
    c = 2'd0;
    case (key)
      8'h31: begin r = 2'd0; c = 2'd0; end
      8'h32: begin r = 2'd0; c = 2'd1; end
      8'h33: begin r = 2'd0; c = 2'd2; end
      8'h41: begin r = 2'd0; c = 2'd3; end
      8'h34: begin r = 2'd1; c = 2'd0; end
      8'h35: begin r = 2'd1; c = 2'd1; end
      8'h36: begin r = 2'd1; c = 2'd2; end
      8'h42: begin r = 2'd1; c = 2'd3; end
      8'h37: begin r = 2'd2; c = 2'd0; end
      8'h38: begin r = 2'd2; c = 2'd1; end
      8'h39: begin r = 2'd2; c = 2'd2; end
      8'h43: begin r = 2'd2; c = 2'd3; end
      8'h2A: begin r = 2'd3; c = 2'd0; end
      8'h30: begin r = 2'd3; c = 2'd1; end
      8'h23: begin r = 2'd3; c = 2'd2; end
      8'h44: begin r = 2'd3; c = 2'd3; end
      default: v = 1'b0;
    endcase
    res.valid = v;
    res.row = v ? ROW_COEF[r] : 16'd0;
    res.col = v ? COL_COEF[c] : 16'd0;
    return res;
  endfunction

  // s0 = m(c, s1 << 1) - s2, all modulo 2^32
  function automatic logic [31:0] osc_next(input logic [15:0] c, input logic [31:0] s1,
                                           input logic [31:0] s2);
    logic [31:0]        x;
    logic signed [33:0] lo;
    logic signed [31:0] hi;
    logic [31:0]        m;
    x = {s1[30:0], 1'b0};
    lo = $signed({18'd0, x[15:0]}) * $signed({{18{c[15]}}, c}) + MUL_RND;
    hi = $signed({{16{x[31]}}, x[31:16]}) * $signed({{16{c[15]}}, c});
    m = {hi[30:0], 1'b0} + {{13{lo[33]}}, lo[33:15]};
    return m - s2;
  endfunction

endpackage

// ===== rtl/dtmf_tone_sequence_generator_top.sv =====
// Top level: key store, frame sequencer and dual resonator of the DTMF tone sequence generator.
`timescale 1ns / 1ps
// Takes one item per clock unless a stalled result holds the input: loads and clears are
// taken while idle, and each sample tick during playback yields the next audio sample.
// Every accepted item produces exactly one result, shown in the output register on the
// cycle after acceptance; a stalled result holds that register and stalls the input. The
// frame sequencer, key decode and both second-order resonators (four 16x16 multipliers) are
// combinational, so the sustained rate is one item per cycle whenever the output side takes results.
module dtmf_tone_sequence_generator_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  dtsg_pkg::dtsg_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output dtsg_pkg::dtsg_out_t                 out_data,
  input  logic                                cfg_we,
  input  logic [dtsg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dtsg_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic [15:0] tone_frames_r, pause_frames_r, frame_length_r;

  logic [7:0] key_store_r [dtsg_pkg::MAX_KEYS];

  logic [dtsg_pkg::KEY_CNT_W-1:0] keys_stored_r, keys_stored_nxt;
  logic [dtsg_pkg::KEY_CNT_W-1:0] keys_left_r, keys_left_nxt;
  logic [dtsg_pkg::KEY_IDX_W-1:0] read_index_r, read_index_nxt;
  logic                           busy_r, busy_nxt;
  logic                           tone_phase_r, tone_phase_nxt;
  logic [15:0]                    tone_left_r, tone_left_nxt;
  logic [15:0]                    pause_left_r, pause_left_nxt;
  logic [15:0]                    sample_index_r, sample_index_nxt;
  logic [15:0]                    row_coeff_r, row_coeff_nxt, col_coeff_r, col_coeff_nxt;
  logic [31:0]                    row_s1_r, row_s1_nxt, row_s2_r, row_s2_nxt;
  logic [31:0]                    col_s1_r, col_s1_nxt, col_s2_r, col_s2_nxt;

  logic                out_valid_r;
  dtsg_pkg::dtsg_out_t out_data_r, res;

  logic                           accept_in;
  logic                           store_we;
  logic                           load;
  logic                           produce;
  logic                           acc;
  logic [dtsg_pkg::KEY_IDX_W-1:0] key_addr;
  logic [dtsg_pkg::KEY_CNT_W-1:0] cnt_after;
  logic [16:0]                    idx_inc;

  dtsg_pkg::dtsg_coef_t kc;
  logic [15:0] row_c, col_c;
  logic [31:0] row_s1_c, row_s2_c, col_s1_c, col_s2_c;
  logic [31:0] osc_a, osc_b, osc_sum;
  logic        tone_out;

  assign in_stall  = out_valid_r && out_stall;
  assign accept_in = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    keys_stored_nxt  = keys_stored_r;
    keys_left_nxt    = keys_left_r;
    read_index_nxt   = read_index_r;
    busy_nxt         = busy_r;
    tone_phase_nxt   = tone_phase_r;
    tone_left_nxt    = tone_left_r;
    pause_left_nxt   = pause_left_r;
    sample_index_nxt = sample_index_r;
    store_we         = 1'b0;
    load             = 1'b0;
    produce          = 1'b0;
    acc              = 1'b0;
    key_addr         = read_index_r;
    cnt_after        = keys_stored_r;
    idx_inc          = {1'b0, sample_index_r} + 17'd1;
    case (in_data.action)
      dtsg_pkg::ACT_LOAD: begin
        if (!busy_r) begin
          acc = 1'b1;
          if (keys_stored_r < dtsg_pkg::KEY_CNT_W'(dtsg_pkg::MAX_KEYS)) begin
            store_we  = 1'b1;
            cnt_after = keys_stored_r + dtsg_pkg::KEY_CNT_W'(1);
          end
          keys_stored_nxt = cnt_after;
          if (in_data.last_key) begin
            keys_left_nxt    = cnt_after;
            keys_stored_nxt  = '0;
            read_index_nxt   = '0;
            tone_left_nxt    = tone_frames_r;
            pause_left_nxt   = pause_frames_r;
            sample_index_nxt = '0;
            tone_phase_nxt   = 1'b0;
            busy_nxt         = (cnt_after != '0);
          end
        end
      end
      dtsg_pkg::ACT_CLEAR: begin
        if (!busy_r) begin
          acc = 1'b1;
          keys_stored_nxt = '0;
        end
      end
      dtsg_pkg::ACT_TICK: begin
        if (busy_r) begin
          if (sample_index_r == '0) begin
            if (keys_left_r == '0) begin
              busy_nxt       = 1'b0;
              tone_phase_nxt = 1'b0;
            end else if (tone_left_r != '0) begin
              load           = (tone_left_r == tone_frames_r);
              tone_left_nxt  = tone_left_r - 16'd1;
              tone_phase_nxt = 1'b1;
            end else if (pause_left_r != '0) begin
              load           = (tone_frames_r == '0);
              pause_left_nxt = pause_left_r - 16'd1;
              tone_phase_nxt = 1'b0;
            end else begin
              // advance to the next key
              keys_left_nxt  = keys_left_r - dtsg_pkg::KEY_CNT_W'(1);
              read_index_nxt = read_index_r + dtsg_pkg::KEY_IDX_W'(1);
              tone_left_nxt  = tone_frames_r;
              pause_left_nxt = pause_frames_r;
              tone_phase_nxt = 1'b0;
              if (keys_left_r == dtsg_pkg::KEY_CNT_W'(1)) begin
                load     = (tone_frames_r == '0);
                busy_nxt = 1'b0;
              end else if (tone_frames_r != '0) begin
                load           = 1'b1;
                key_addr       = read_index_nxt;
                tone_left_nxt  = tone_frames_r - 16'd1;
                tone_phase_nxt = 1'b1;
              end else if (pause_frames_r != '0) begin
                load           = 1'b1;
                key_addr       = read_index_nxt;
                pause_left_nxt = pause_frames_r - 16'd1;
              end else begin
                // nothing to play for any key: drop the rest of the string, keep the last key
                load          = 1'b1;
                key_addr      = read_index_r + keys_left_r[dtsg_pkg::KEY_IDX_W-1:0]
                                - dtsg_pkg::KEY_IDX_W'(1);
                busy_nxt      = 1'b0;
                keys_left_nxt = '0;
              end
            end
          end
          if (busy_nxt) begin
            produce = 1'b1;
            sample_index_nxt = (idx_inc >= {1'b0, frame_length_r}) ? 16'd0 : idx_inc[15:0];
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    kc       = dtsg_pkg::key_coef(key_store_r[key_addr]);
    row_c    = load ? kc.row : row_coeff_r;
    col_c    = load ? kc.col : col_coeff_r;
    row_s1_c = load ? {16'd0, kc.row} : row_s1_r;
    col_s1_c = load ? {16'd0, kc.col} : col_s1_r;
    row_s2_c = load ? (kc.valid ? dtsg_pkg::S2_INIT : 32'd0) : row_s2_r;
    col_s2_c = load ? (kc.valid ? dtsg_pkg::S2_INIT : 32'd0) : col_s2_r;
    osc_a    = dtsg_pkg::osc_next(row_c, row_s1_c, row_s2_c);
    osc_b    = dtsg_pkg::osc_next(col_c, col_s1_c, col_s2_c);
    osc_sum  = osc_a + osc_b;
    tone_out = produce && tone_phase_nxt;

    row_coeff_nxt = row_c;
    col_coeff_nxt = col_c;
    row_s1_nxt    = tone_out ? osc_a : row_s1_c;
    row_s2_nxt    = tone_out ? row_s1_c : row_s2_c;
    col_s1_nxt    = tone_out ? osc_b : col_s1_c;
    col_s2_nxt    = tone_out ? col_s1_c : col_s2_c;

    res          = '0;
    res.active   = produce;
    res.in_tone  = tone_out;
    res.accepted = acc;
    if (tone_out && !(row_c == '0 && col_c == '0)) begin
      res.sample = $signed(osc_sum[16:1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tone_frames_r  <= dtsg_pkg::TONE_FRAMES_RST;
      pause_frames_r <= dtsg_pkg::PAUSE_FRAMES_RST;
      frame_length_r <= dtsg_pkg::FRAME_LENGTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        dtsg_pkg::CFG_TONE_FRAMES:  tone_frames_r  <= cfg_wdata;
        dtsg_pkg::CFG_PAUSE_FRAMES: pause_frames_r <= cfg_wdata;
        dtsg_pkg::CFG_FRAME_LENGTH: frame_length_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in && store_we) begin
      key_store_r[keys_stored_r[dtsg_pkg::KEY_IDX_W-1:0]] <= in_data.key_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keys_stored_r  <= '0;
      keys_left_r    <= '0;
      read_index_r   <= '0;
      busy_r         <= 1'b0;
      tone_phase_r   <= 1'b0;
      tone_left_r    <= '0;
      pause_left_r   <= '0;
      sample_index_r <= '0;
      row_coeff_r    <= '0;
      col_coeff_r    <= '0;
      row_s1_r       <= '0;
      row_s2_r       <= '0;
      col_s1_r       <= '0;
      col_s2_r       <= '0;
    end else if (accept_in) begin
      keys_stored_r  <= keys_stored_nxt;
      keys_left_r    <= keys_left_nxt;
      read_index_r   <= read_index_nxt;
      busy_r         <= busy_nxt;
      tone_phase_r   <= tone_phase_nxt;
      tone_left_r    <= tone_left_nxt;
      pause_left_r   <= pause_left_nxt;
      sample_index_r <= sample_index_nxt;
      row_coeff_r    <= row_coeff_nxt;
      col_coeff_r    <= col_coeff_nxt;
      row_s1_r       <= row_s1_nxt;
      row_s2_r       <= row_s2_nxt;
      col_s1_r       <= col_s1_nxt;
      col_s2_r       <= col_s2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept_in) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      out_data_r <= res;
    end
  end

endmodule

// ===== rtl/dtsg_checker.sv =====
// Checker: port-level assertions for the DTMF tone sequence generator, bound to its top level.
`timescale 1ns / 1ps
module dtsg_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input dtsg_pkg::dtsg_out_t             out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_item_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted item produced no result");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with free output register");

endmodule

bind dtmf_tone_sequence_generator_top dtsg_checker u_dtsg_checker (.*);
